// File: hw/rtl/rbs_pkg.sv
// Shared constants, types and register codes for the 2D ray/box slab test.
`timescale 1ns / 1ps

package rbs_pkg;

    // Coordinate format and field widths.
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int LEN_WIDTH   = 31;

    // Width that holds both a signed coordinate and the unsigned length.
    localparam int CMP_WIDTH = ((COORD_WIDTH > LEN_WIDTH) ? COORD_WIDTH : LEN_WIDTH) + 1;

    // Divider depth: setup stage, one stage per quotient bit, result stage.
    localparam int DIV_LAT    = COORD_WIDTH + 2;
    // Whole pipeline: input stage, magnitude stage, divider, slab, merge, output.
    localparam int NUM_STAGES = DIV_LAT + 5;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t T_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t T_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_BOX_MIN_X = 2'd0,
        CFG_BOX_MIN_Y = 2'd1,
        CFG_BOX_MAX_X = 2'd2,
        CFG_BOX_MAX_Y = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t max_x;
        coord_t max_y;
    } box_t;

    // Per-ray information that bypasses the dividers.
    typedef struct packed {
        logic                 zero_x;
        logic                 zero_y;
        logic                 in_x;
        logic                 in_y;
        logic [LEN_WIDTH-1:0] length_limit;
    } side_t;

endpackage

// File: hw/rtl/rbs_cfg_if.sv
// Configuration write channel of the ray/box slab test.
`timescale 1ns / 1ps

interface rbs_cfg_if import rbs_pkg::*; ();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    coord_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/rbs_ray_if.sv
// Ray request channel of the ray/box slab test.
`timescale 1ns / 1ps

interface rbs_ray_if import rbs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    coord_t               origin_x;
    coord_t               origin_y;
    coord_t               dir_x;
    coord_t               dir_y;
    logic [LEN_WIDTH-1:0] length_limit;

    modport source (output valid, output origin_x, output origin_y, output dir_x,
                    output dir_y, output length_limit, input ready);
    modport sink   (input valid, input origin_x, input origin_y, input dir_x,
                    input dir_y, input length_limit, output ready);
endinterface

// File: hw/rtl/rbs_res_if.sv
// Result channel of the ray/box slab test.
`timescale 1ns / 1ps

interface rbs_res_if import rbs_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   hit;
    coord_t t_enter;
    coord_t t_exit;

    modport source (output valid, output hit, output t_enter, output t_exit, input ready);
    modport sink   (input valid, input hit, input t_enter, input t_exit, output ready);
endinterface

// File: hw/rtl/rbs_cfg.sv
// Box bound registers written through the configuration channel.
`timescale 1ns / 1ps

module rbs_cfg import rbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rbs_cfg_if.sink   cfg,
    output box_t      box
);

    box_t box_reg;

    // Writes are always taken.
    assign cfg.ready = 1'b1;

    // Register write decode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BOX_MIN_X: box_reg.min_x <= cfg.data;
                CFG_BOX_MIN_Y: box_reg.min_y <= cfg.data;
                CFG_BOX_MAX_X: box_reg.max_x <= cfg.data;
                CFG_BOX_MAX_Y: box_reg.max_y <= cfg.data;
                default:       box_reg       <= box_reg;
            endcase
        end
    end

    assign box = box_reg;

endmodule

// File: hw/rtl/rbs_div.sv
// Pipelined fixed-point divider, one quotient bit per stage, saturating result.
`timescale 1ns / 1ps

module rbs_div import rbs_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [COORD_WIDTH-1:0] num,
    input  logic [COORD_WIDTH-1:0] den,
    input  logic                   neg,
    output coord_t                 quo
);

    localparam int W = COORD_WIDTH;
    localparam int F = FRAC_BITS;
    localparam logic [W-1:0] LIM = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0] rem_reg [0:W];
    logic [W-1:0] nsh_reg [0:W-1];
    logic [W-1:0] q_reg   [0:W];
    logic [W-1:0] den_reg [0:W-1];
    logic         neg_reg [0:W];
    logic         sat_reg [0:W];
    coord_t       quo_reg;

    logic [W+F:0] num_ext;
    logic         sat_first;
    logic         sat_all;
    coord_t       quo_next;

    // Setup: the scaled numerator's bits above the quotient window either
    // overflow the result right away or form the starting remainder.
    assign num_ext   = (W+F+1)'(num) << F;
    assign sat_first = (W+F+1)'(num_ext[W+F:W]) >= (W+F+1)'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= W'(num_ext[W+F:W]);
            nsh_reg[0] <= num_ext[W-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= neg;
            sat_reg[0] <= sat_first;
        end
    end

    // Restoring division steps.
    for (genvar k = 1; k <= W; k++)
    begin : g_step
        logic [W:0] trial;
        logic [W:0] diff;
        logic       take;

        assign trial = {rem_reg[k-1], nsh_reg[k-1][W-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};
        assign take  = trial >= {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? diff[W-1:0] : trial[W-1:0];
                q_reg[k]   <= {q_reg[k-1][W-2:0], take};
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end

        // Numerator bits and divisor are needed only by the later steps.
        if (k < W)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nsh_reg[k] <= {nsh_reg[k-1][W-2:0], 1'b0};
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    // Sign and saturation of the finished quotient.
    assign sat_all = sat_reg[W] || (q_reg[W] >= LIM);

    always_comb
    begin
        if (sat_all)
            quo_next = neg_reg[W] ? T_MIN : T_MAX;
        else if (neg_reg[W])
            quo_next = coord_t'(-q_reg[W]);
        else
            quo_next = coord_t'(q_reg[W]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

// File: hw/rtl/ray_box_slab_test_2d_core.sv
// Top level of the 2D ray against axis-aligned box slab test.
`timescale 1ns / 1ps

// Tests each ray request against the box held in the four bound registers
// and returns one result per ray, in order. The pipeline takes one ray every
// cycle while the output is not held; its four dividers produce one quotient
// bit per stage. The whole pipeline holds while a result waits at the output,
// so ray ready is low only while a valid result is not yet taken by the result
// channel.
// Box registers should be written only while no ray is in flight.
module ray_box_slab_test_2d_core import rbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rbs_cfg_if.sink    cfg,
    rbs_ray_if.sink    ray,
    rbs_res_if.source  res
);

    localparam int W = COORD_WIDTH;

    box_t box;
    logic en;
    logic [NUM_STAGES-1:0] vld_reg;

    rbs_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .box   (box)
    );

    // Global advance: the pipeline moves unless the output holds an untaken result.
    assign en        = !vld_reg[NUM_STAGES-1] || res.ready;
    assign ray.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NUM_STAGES-2:0], ray.valid};
    end

    // Stage A: bound minus origin, zero direction and in-slab checks.
    logic signed [W:0] a_dminx_reg, a_dmaxx_reg, a_dminy_reg, a_dmaxy_reg;
    coord_t            a_dirx_reg, a_diry_reg;
    side_t             a_side_reg;
    side_t             a_side_next;

    always_comb
    begin
        a_side_next.zero_x       = ray.dir_x == '0;
        a_side_next.zero_y       = ray.dir_y == '0;
        a_side_next.in_x         = (ray.origin_x >= box.min_x) && (ray.origin_x <= box.max_x);
        a_side_next.in_y         = (ray.origin_y >= box.min_y) && (ray.origin_y <= box.max_y);
        a_side_next.length_limit = ray.length_limit;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dminx_reg <= {box.min_x[W-1], box.min_x} - {ray.origin_x[W-1], ray.origin_x};
            a_dmaxx_reg <= {box.max_x[W-1], box.max_x} - {ray.origin_x[W-1], ray.origin_x};
            a_dminy_reg <= {box.min_y[W-1], box.min_y} - {ray.origin_y[W-1], ray.origin_y};
            a_dmaxy_reg <= {box.max_y[W-1], box.max_y} - {ray.origin_y[W-1], ray.origin_y};
            a_dirx_reg  <= ray.dir_x;
            a_diry_reg  <= ray.dir_y;
            a_side_reg  <= a_side_next;
        end
    end

    // Stage B: magnitudes and quotient signs for the dividers.
    logic [W-1:0] b_nminx_reg, b_nmaxx_reg, b_nminy_reg, b_nmaxy_reg;
    logic [W-1:0] b_denx_reg, b_deny_reg;
    logic         b_gminx_reg, b_gmaxx_reg, b_gminy_reg, b_gmaxy_reg;
    side_t        b_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_nminx_reg <= W'(a_dminx_reg[W] ? -a_dminx_reg : a_dminx_reg);
            b_nmaxx_reg <= W'(a_dmaxx_reg[W] ? -a_dmaxx_reg : a_dmaxx_reg);
            b_nminy_reg <= W'(a_dminy_reg[W] ? -a_dminy_reg : a_dminy_reg);
            b_nmaxy_reg <= W'(a_dmaxy_reg[W] ? -a_dmaxy_reg : a_dmaxy_reg);
            b_denx_reg  <= a_dirx_reg[W-1] ? W'(-a_dirx_reg) : W'(a_dirx_reg);
            b_deny_reg  <= a_diry_reg[W-1] ? W'(-a_diry_reg) : W'(a_diry_reg);
            b_gminx_reg <= a_dminx_reg[W] ^ a_dirx_reg[W-1];
            b_gmaxx_reg <= a_dmaxx_reg[W] ^ a_dirx_reg[W-1];
            b_gminy_reg <= a_dminy_reg[W] ^ a_diry_reg[W-1];
            b_gmaxy_reg <= a_dmaxy_reg[W] ^ a_diry_reg[W-1];
            b_side_reg  <= a_side_reg;
        end
    end

    // Four slab dividers.
    coord_t t1x, t2x, t1y, t2y;

    rbs_div u_div_minx (.clk(clk), .en(en), .num(b_nminx_reg), .den(b_denx_reg),
                        .neg(b_gminx_reg), .quo(t1x));
    rbs_div u_div_maxx (.clk(clk), .en(en), .num(b_nmaxx_reg), .den(b_denx_reg),
                        .neg(b_gmaxx_reg), .quo(t2x));
    rbs_div u_div_miny (.clk(clk), .en(en), .num(b_nminy_reg), .den(b_deny_reg),
                        .neg(b_gminy_reg), .quo(t1y));
    rbs_div u_div_maxy (.clk(clk), .en(en), .num(b_nmaxy_reg), .den(b_deny_reg),
                        .neg(b_gmaxy_reg), .quo(t2y));

    // Side information delayed to line up with the quotients.
    side_t dly_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= b_side_reg;
            for (int i = 1; i < DIV_LAT; i++)
                dly_reg[i] <= dly_reg[i-1];
        end
    end

    // Stage C: per-axis entry and exit.
    coord_t c_lox_reg, c_hix_reg, c_loy_reg, c_hiy_reg;
    logic [LEN_WIDTH-1:0] c_len_reg;
    side_t  c_side;

    assign c_side = dly_reg[DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (c_side.zero_x)
            begin
                c_lox_reg <= c_side.in_x ? T_MIN : T_MAX;
                c_hix_reg <= c_side.in_x ? T_MAX : T_MIN;
            end
            else
            begin
                c_lox_reg <= (t1x < t2x) ? t1x : t2x;
                c_hix_reg <= (t1x < t2x) ? t2x : t1x;
            end
            if (c_side.zero_y)
            begin
                c_loy_reg <= c_side.in_y ? T_MIN : T_MAX;
                c_hiy_reg <= c_side.in_y ? T_MAX : T_MIN;
            end
            else
            begin
                c_loy_reg <= (t1y < t2y) ? t1y : t2y;
                c_hiy_reg <= (t1y < t2y) ? t2y : t1y;
            end
            c_len_reg <= c_side.length_limit;
        end
    end

    // Stage D: overall entry and exit.
    coord_t d_tmin_reg, d_tmax_reg;
    logic [LEN_WIDTH-1:0] d_len_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_tmin_reg <= (c_lox_reg > c_loy_reg) ? c_lox_reg : c_loy_reg;
            d_tmax_reg <= (c_hix_reg < c_hiy_reg) ? c_hix_reg : c_hiy_reg;
            d_len_reg  <= c_len_reg;
        end
    end

    // Stage E: hit decision and clipping, held in the output register.
    logic signed [CMP_WIDTH-1:0] tmin_w, tmax_w, len_w;
    logic   e_hit_reg;
    coord_t e_enter_reg, e_exit_reg;

    assign tmin_w = CMP_WIDTH'(d_tmin_reg);
    assign tmax_w = CMP_WIDTH'(d_tmax_reg);
    assign len_w  = $signed(CMP_WIDTH'(d_len_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_hit_reg   <= !d_tmax_reg[W-1] && (tmin_w <= len_w) && (d_tmin_reg <= d_tmax_reg);
            e_enter_reg <= d_tmin_reg[W-1] ? '0 : d_tmin_reg;
            e_exit_reg  <= (tmax_w < len_w) ? d_tmax_reg : coord_t'(len_w[W-1:0]);
        end
    end

    assign res.valid   = vld_reg[NUM_STAGES-1];
    assign res.hit     = e_hit_reg;
    assign res.t_enter = e_enter_reg;
    assign res.t_exit  = e_exit_reg;

`ifndef SYNTH
    // A hit always has an entry no later than its exit.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.hit |-> res.t_enter <= res.t_exit)
        else $error("hit result with entry after exit");

    // The clipped entry is never negative.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !res.t_enter[W-1])
        else $error("negative clipped entry");

    // A hit never reports a negative exit.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.hit |-> !res.t_exit[W-1])
        else $error("hit result with negative exit");

    // An accepted ray enters the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        ray.valid && ray.ready |=> vld_reg[0])
        else $error("accepted ray lost at pipeline entry");
`endif

endmodule
